/* design/sacl_pkg.sv */
`default_nettype none

package sacl_pkg;

  // fixed field widths
  localparam int ADDR_W       = 64;
  localparam int TAG_W        = 62;  // set and offset take at least two bits
  localparam int SET_BITS_W   = 4;
  localparam int BLOCK_BITS_W = 6;
  localparam int WAYS_W       = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;
  localparam int TOTAL_W      = 32;

  localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 4'd4;
  localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 6'd4;
  localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_LOOK   = 2'd1,
    ST_REREAD = 2'd2
  } state_e;

  typedef struct packed {
    logic hit;
    logic miss;
    logic evicted;
  } lk_res_t;

endpackage

`default_nettype wire

/* design/sacl_in_if.sv */
`default_nettype none

interface sacl_in_if import sacl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output mode, output address, input ready);
  modport sink (input valid, input mode, input address, output ready);
endinterface

`default_nettype wire

/* design/sacl_out_if.sv */
`default_nettype none

interface sacl_out_if import sacl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               hit;
  logic               miss;
  logic               evicted;
  logic               last;
  logic [TOTAL_W-1:0] hit_total;
  logic [TOTAL_W-1:0] miss_total;

  modport source (
    output valid, output hit, output miss, output evicted, output last,
    output hit_total, output miss_total, input ready
  );
  modport sink (
    input valid, input hit, input miss, input evicted, input last,
    input hit_total, input miss_total, output ready
  );
endinterface

`default_nettype wire

/* design/sacl_addr_split.sv */
`default_nettype none

module sacl_addr_split import sacl_pkg::*; #(
  parameter int INDEX_BITS_MAX = 8
) (
  input  logic [ADDR_W-1:0]         address_i,
  input  logic [SET_BITS_W-1:0]     set_bits_i,
  input  logic [BLOCK_BITS_W-1:0]   block_bits_i,
  output logic [INDEX_BITS_MAX-1:0] set_o,
  output logic [TAG_W-1:0]          tag_o
);

  logic [SET_BITS_W-1:0]   sb;
  logic [BLOCK_BITS_W-1:0] bb;
  logic [BLOCK_BITS_W:0]   total;
  logic [ADDR_W-1:0]       blk_addr;
  logic [ADDR_W-1:0]       tag_full;

  always_comb begin
    // clamp the field widths
    if (set_bits_i == '0) begin
      sb = SET_BITS_W'(1);
    end else if (32'(set_bits_i) > INDEX_BITS_MAX) begin
      sb = SET_BITS_W'(INDEX_BITS_MAX);
    end else begin
      sb = set_bits_i;
    end
    bb = (block_bits_i == '0) ? BLOCK_BITS_W'(1) : block_bits_i;

    total    = {1'b0, bb} + (BLOCK_BITS_W + 1)'(sb);
    blk_addr = address_i >> bb;
    set_o    = blk_addr[INDEX_BITS_MAX-1:0] & ~({INDEX_BITS_MAX{1'b1}} << sb);
    tag_full = (32'(total) >= ADDR_W) ? '0 : (address_i >> total);
    tag_o    = tag_full[TAG_W-1:0];
  end

endmodule

`default_nettype wire

/* design/sacl_row_mem.sv */
`default_nettype none

module sacl_row_mem import sacl_pkg::*; #(
  parameter int INDEX_BITS_MAX = 8,
  parameter int WAYS_MAX       = 8,
  parameter int RANK_W         = 3
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 rd_en_i,
  input  logic [INDEX_BITS_MAX-1:0]            rd_set_i,
  output logic [WAYS_MAX-1:0]                  rd_valid_o,
  output logic [WAYS_MAX-1:0][RANK_W-1:0]      rd_rank_o,
  output logic [WAYS_MAX-1:0][TAG_W-1:0]       rd_tag_o,
  input  logic                                 wr_en_i,
  input  logic [INDEX_BITS_MAX-1:0]            wr_set_i,
  input  logic [WAYS_MAX-1:0]                  wr_valid_i,
  input  logic [WAYS_MAX-1:0][RANK_W-1:0]      wr_rank_i,
  input  logic [WAYS_MAX-1:0][TAG_W-1:0]       wr_tag_i
);

  localparam int ROWS  = 1 << INDEX_BITS_MAX;
  localparam int ROW_W = WAYS_MAX * (1 + RANK_W + TAG_W);

  logic [ROW_W-1:0] row_ram [ROWS];
  logic [ROW_W-1:0] rd_word_q;
  logic [ROW_W-1:0] wr_word;
  logic [ROWS-1:0]  seen_q;      // row written since reset
  logic             seen_rd_q;

  logic [WAYS_MAX-1:0]             raw_valid;
  logic [WAYS_MAX-1:0][RANK_W-1:0] raw_rank;

  assign wr_word = {wr_valid_i, wr_rank_i, wr_tag_i};

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      row_ram[wr_set_i] <= wr_word;
    end
    if (rd_en_i) begin
      rd_word_q <= row_ram[rd_set_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= '0;
      seen_rd_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        seen_q[wr_set_i] <= 1'b1;
      end
      if (rd_en_i) begin
        seen_rd_q <= seen_q[rd_set_i];
      end
    end
  end

  // an unwritten row reads as all invalid with zero ranks
  assign {raw_valid, raw_rank, rd_tag_o} = rd_word_q;
  assign rd_valid_o = seen_rd_q ? raw_valid : '0;
  assign rd_rank_o  = seen_rd_q ? raw_rank  : '0;

endmodule

`default_nettype wire

/* design/sacl_lookup.sv */
`default_nettype none

module sacl_lookup import sacl_pkg::*; #(
  parameter int WAYS_MAX = 8,
  parameter int RANK_W   = 3,
  parameter int NW_W     = 4
) (
  input  logic [WAYS_MAX-1:0]             valid_i,
  input  logic [WAYS_MAX-1:0][RANK_W-1:0] rank_i,
  input  logic [WAYS_MAX-1:0][TAG_W-1:0]  row_tag_i,
  input  logic [TAG_W-1:0]                lk_tag_i,
  input  logic [NW_W-1:0]                 nways_i,
  output lk_res_t                         res_o,
  output logic [WAYS_MAX-1:0]             new_valid_o,
  output logic [WAYS_MAX-1:0][RANK_W-1:0] new_rank_o,
  output logic [WAYS_MAX-1:0][TAG_W-1:0]  new_tag_o
);

  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS_MAX - 1);

  logic [WAYS_MAX-1:0] active;
  logic                found;
  logic                full;
  logic                free_found;
  logic [RANK_W-1:0]   hit_way;
  logic [RANK_W-1:0]   vic_way;
  logic [RANK_W-1:0]   free_way;
  logic [RANK_W-1:0]   way;
  logic [RANK_W-1:0]   old_rank;

  always_comb begin
    found      = 1'b0;
    full       = 1'b1;
    free_found = 1'b0;
    hit_way    = '0;
    vic_way    = '0;
    free_way   = '0;

    for (int i = 0; i < WAYS_MAX; i++) begin
      active[i] = (NW_W'(i) < nways_i);
    end

    // lowest matching way, and whether the active ways are all in use
    for (int i = 0; i < WAYS_MAX; i++) begin
      if (active[i]) begin
        if (valid_i[i]) begin
          if (!found && (row_tag_i[i] == lk_tag_i)) begin
            found   = 1'b1;
            hit_way = RANK_W'(i);
          end
        end else begin
          full = 1'b0;
          if (!free_found) begin
            free_found = 1'b1;
            free_way   = RANK_W'(i);
          end
        end
      end
    end

    // oldest active way, ties to the lowest
    for (int i = 1; i < WAYS_MAX; i++) begin
      if (active[i] && (rank_i[i] > rank_i[vic_way])) begin
        vic_way = RANK_W'(i);
      end
    end

    if (found) begin
      way      = hit_way;
      old_rank = rank_i[hit_way];
    end else if (full) begin
      way      = vic_way;
      old_rank = rank_i[vic_way];
    end else begin
      way      = free_way;
      old_rank = RANK_MAX;
    end

    new_valid_o = valid_i;
    new_rank_o  = rank_i;
    new_tag_o   = row_tag_i;
    for (int i = 0; i < WAYS_MAX; i++) begin
      if (active[i] && (RANK_W'(i) != way) && valid_i[i] && (rank_i[i] < old_rank)) begin
        new_rank_o[i] = rank_i[i] + RANK_W'(1);
      end
    end
    new_rank_o[way]  = '0;
    new_valid_o[way] = 1'b1;
    if (!found) begin
      new_tag_o[way] = lk_tag_i;
    end

    res_o.hit     = found;
    res_o.miss    = !found;
    res_o.evicted = !found && full;
  end

endmodule

`default_nettype wire

/* design/set_assoc_cache_lru_sim.sv */
`default_nettype none

// channel   dir  payload                                          transaction
// in_i      in   mode, address                                    valid && ready
// out_o     out  hit, miss, evicted, last, hit_total, miss_total  valid && ready
// cfg       in   cfg_idx_i, cfg_data_i                            cfg_we_i
//
// one lookup reads the set row from the row ram in the cycle the transaction
// is taken, then compares it, updates it and writes it back
// a modify access rereads the written-back row and runs a second lookup
// a new item is taken only once the previous item is finished
// a lookup waits while the output register still holds an untaken result
// reset clears the per-row written flags at once, so no clearing pass runs

module set_assoc_cache_lru_sim import sacl_pkg::*; #(
  parameter int INDEX_BITS_MAX = 8,
  parameter int WAYS_MAX       = 8,
  parameter int COUNT_BITS     = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sacl_in_if.sink               in_i,
  sacl_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int RANK_W = (WAYS_MAX > 1) ? $clog2(WAYS_MAX) : 1;
  localparam int NW_W   = $clog2(WAYS_MAX + 1);

  // configuration registers
  logic [SET_BITS_W-1:0]   set_bits_q;
  logic [BLOCK_BITS_W-1:0] block_bits_q;
  logic [WAYS_W-1:0]       ways_q;
  logic [NW_W-1:0]         nways;

  // control
  state_e state_q, state_d;
  logic   second_q, second_d;
  logic   mode_q;
  logic   in_accept;
  logic   slot_free;
  logic   emit;
  logic   rd_en;
  logic   in_ready;

  // lookup operands
  logic [INDEX_BITS_MAX-1:0] split_set;
  logic [TAG_W-1:0]          split_tag;
  logic [INDEX_BITS_MAX-1:0] set_q;
  logic [TAG_W-1:0]          tag_q;
  logic [INDEX_BITS_MAX-1:0] rd_set;

  // row data
  logic [WAYS_MAX-1:0]             rd_valid;
  logic [WAYS_MAX-1:0][RANK_W-1:0] rd_rank;
  logic [WAYS_MAX-1:0][TAG_W-1:0]  rd_tag;
  logic [WAYS_MAX-1:0]             new_valid;
  logic [WAYS_MAX-1:0][RANK_W-1:0] new_rank;
  logic [WAYS_MAX-1:0][TAG_W-1:0]  new_tag;
  lk_res_t                         res;

  // running totals
  logic [COUNT_BITS-1:0] hits_seen_q, hits_seen_d;
  logic [COUNT_BITS-1:0] misses_seen_q, misses_seen_d;
  logic [COUNT_BITS-1:0] evictions_seen_q, evictions_seen_d;

  // output register
  logic               out_valid_q;
  logic               out_hit_q;
  logic               out_miss_q;
  logic               out_evicted_q;
  logic               out_last_q;
  logic [TOTAL_W-1:0] out_hit_total_q;
  logic [TOTAL_W-1:0] out_miss_total_q;

  // configuration writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= SET_BITS_RST;
      block_bits_q <= BLOCK_BITS_RST;
      ways_q       <= WAYS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SET_BITS:   set_bits_q   <= cfg_data_i[SET_BITS_W-1:0];
        CFG_BLOCK_BITS: block_bits_q <= cfg_data_i[BLOCK_BITS_W-1:0];
        CFG_WAYS:       ways_q       <= cfg_data_i[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // active way count, zero acts as one and large values clip
  always_comb begin
    if (ways_q == '0) begin
      nways = NW_W'(1);
    end else if (32'(ways_q) > WAYS_MAX) begin
      nways = NW_W'(WAYS_MAX);
    end else begin
      nways = NW_W'(ways_q);
    end
  end

  sacl_addr_split #(
    .INDEX_BITS_MAX (INDEX_BITS_MAX)
  ) u_split (
    .address_i    (in_i.address),
    .set_bits_i   (set_bits_q),
    .block_bits_i (block_bits_q),
    .set_o        (split_set),
    .tag_o        (split_tag)
  );

  // handshake terms
  assign in_accept = in_i.valid && in_ready;
  assign slot_free = !out_valid_q || out_o.ready;

  // next state
  always_comb begin
    state_d  = state_q;
    second_d = second_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d  = ST_LOOK;
          second_d = 1'b0;
        end
      end
      ST_LOOK: begin
        if (slot_free) begin
          if (mode_q && !second_q) begin
            state_d  = ST_REREAD;
            second_d = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_REREAD: begin
        // the row written back last cycle is read again here
        state_d = ST_LOOK;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    rd_set   = set_q;
    emit     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        rd_en    = in_i.valid;
        rd_set   = split_set;
      end
      ST_LOOK: begin
        emit = slot_free;
      end
      ST_REREAD: begin
        rd_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
    end
  end

  // item operands held for both lookups
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q <= in_i.mode;
      set_q  <= split_set;
      tag_q  <= split_tag;
    end
  end

  sacl_row_mem #(
    .INDEX_BITS_MAX (INDEX_BITS_MAX),
    .WAYS_MAX       (WAYS_MAX),
    .RANK_W         (RANK_W)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_set_i   (rd_set),
    .rd_valid_o (rd_valid),
    .rd_rank_o  (rd_rank),
    .rd_tag_o   (rd_tag),
    .wr_en_i    (emit),
    .wr_set_i   (set_q),
    .wr_valid_i (new_valid),
    .wr_rank_i  (new_rank),
    .wr_tag_i   (new_tag)
  );

  sacl_lookup #(
    .WAYS_MAX (WAYS_MAX),
    .RANK_W   (RANK_W),
    .NW_W     (NW_W)
  ) u_lookup (
    .valid_i     (rd_valid),
    .rank_i      (rd_rank),
    .row_tag_i   (rd_tag),
    .lk_tag_i    (tag_q),
    .nways_i     (nways),
    .res_o       (res),
    .new_valid_o (new_valid),
    .new_rank_o  (new_rank),
    .new_tag_o   (new_tag)
  );

  // saturating totals
  always_comb begin
    hits_seen_d      = hits_seen_q;
    misses_seen_d    = misses_seen_q;
    evictions_seen_d = evictions_seen_q;
    if (emit) begin
      if (res.hit && (hits_seen_q != '1)) begin
        hits_seen_d = hits_seen_q + COUNT_BITS'(1);
      end
      if (res.miss && (misses_seen_q != '1)) begin
        misses_seen_d = misses_seen_q + COUNT_BITS'(1);
      end
      if (res.evicted && (evictions_seen_q != '1)) begin
        evictions_seen_d = evictions_seen_q + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_seen_q      <= '0;
      misses_seen_q    <= '0;
      evictions_seen_q <= '0;
    end else begin
      hits_seen_q      <= hits_seen_d;
      misses_seen_q    <= misses_seen_d;
      evictions_seen_q <= evictions_seen_d;
    end
  end

  // output register, refilled only once the previous result is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_hit_q        <= res.hit;
      out_miss_q       <= res.miss;
      out_evicted_q    <= res.evicted;
      out_last_q       <= !mode_q || second_q;
      out_hit_total_q  <= TOTAL_W'(hits_seen_d);
      out_miss_total_q <= TOTAL_W'(misses_seen_d);
    end
  end

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.hit        = out_hit_q;
  assign out_o.miss       = out_miss_q;
  assign out_o.evicted    = out_evicted_q;
  assign out_o.last       = out_last_q;
  assign out_o.hit_total  = out_hit_total_q;
  assign out_o.miss_total = out_miss_total_q;

`ifndef SYNTHESIS
  // an eviction is always part of a miss
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evictions_seen_q <= misses_seen_q)
    else $error("eviction total ran ahead of miss total");

  // the second lookup of a modify access must see its own fill
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && second_q) |-> res.hit)
    else $error("second lookup of a modify access missed");

  // a hit bumps the hit total unless it is saturated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && res.hit && (hits_seen_q != '1)) |=>
      (hits_seen_q == $past(hits_seen_q) + COUNT_BITS'(1)))
    else $error("hit total did not advance on a hit");
`endif

endmodule

`default_nettype wire
